// File: src/ialu_pkg.sv
// package for the integer alu with status flags
// holds operation codes, flag bit positions and controller/datapath structs
// no dependencies
`default_nettype none

package ialu_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int CMD_WIDTH      = 3;
   localparam int FLAG_WIDTH     = 8;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [CMD_WIDTH-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_MOD = 3'd4;

   localparam int FLAG_CARRY  = 0;
   localparam int FLAG_PARITY = 1;
   localparam int FLAG_ZERO   = 3;
   localparam int FLAG_SIGN   = 4;
   localparam int FLAG_OVF    = 5;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic form;
      logic write;
   } ialu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iterate;
   } ialu_status_type;

endpackage

`default_nettype wire

// File: src/ialu_ctrl.sv
// controller state machine for the integer alu
// depends on ialu_pkg
`default_nettype none

module ialu_ctrl #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   input  ialu_pkg::ialu_status_type  status,
   output ialu_pkg::ialu_cmd_type     cmd
);
   import ialu_pkg::*;

   localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(DATA_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FORM,
      ST_WRITE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.step  = (state_ff == ST_RUN);
      cmd.form  = (state_ff == ST_FORM);
      cmd.write = (state_ff == ST_WRITE) && out_free;
   end

   // a new response is raised on a write, an old one drops once taken
   assign rsp_valid_in = cmd.write || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               count_ff <= '0;
               if (req_valid) begin
                  state_ff <= status.iterate ? ST_RUN : ST_FORM;
               end
            end
            ST_RUN: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == LAST_STEP) begin
                  state_ff <= ST_FORM;
               end
            end
            ST_FORM: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: src/ialu_dp.sv
// datapath for the integer alu: operand registers, shared shift-add and
// restoring-divide adder, wide result forming, flag register and output register
// depends on ialu_pkg
`default_nettype none

module ialu_dp #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  ialu_pkg::ialu_cmd_type                   cmd,
   output ialu_pkg::ialu_status_type                status,
   input  wire [ialu_pkg::CMD_WIDTH-1:0]            req_cmd,
   input  wire signed [ialu_pkg::VALUE_WIDTH-1:0]   req_operand_a,
   input  wire signed [ialu_pkg::VALUE_WIDTH-1:0]   req_operand_b,
   output logic signed [ialu_pkg::VALUE_WIDTH-1:0]  rsp_result_value,
   output logic [ialu_pkg::FLAG_WIDTH-1:0]          rsp_status_flags,
   output logic                                     rsp_divide_error
);
   import ialu_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int DW2 = 2 * DATA_WIDTH;
   localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
   localparam logic [FLAG_WIDTH-1:0] FLAG_MASK =
      FLAG_WIDTH'((1 << FLAG_CARRY) | (1 << FLAG_PARITY) | (1 << FLAG_ZERO) |
                  (1 << FLAG_SIGN) | (1 << FLAG_OVF));

   logic [CMD_WIDTH-1:0]  cmd_ff;
   logic [DW-1:0]         a_ff;
   logic [DW-1:0]         b_ff;
   logic [DW-1:0]         ma_ff;
   logic [DW-1:0]         mb_ff;
   logic                  neg_ff;
   logic [DW2-1:0]        p_ff;
   logic [DW2-1:0]        wide_ff;
   logic                  upd_ff;
   logic                  err_ff;
   logic [FLAG_WIDTH-1:0] flag_ff;

   logic [DW-1:0]         a_in;
   logic [DW-1:0]         b_in;
   logic [DW-1:0]         ma_in;
   logic [DW-1:0]         mb_in;
   logic                  is_mul;
   logic                  is_divmod;
   logic [DW:0]           add_x;
   logic [DW:0]           add_y;
   logic [DW+1:0]         add_sum;
   logic                  div_ok;
   logic [DW-1:0]         div_hi;
   logic [DW2-1:0]        p_in;
   logic [DW2-1:0]        wide_in;
   logic                  upd_in;
   logic                  err_in;
   logic [DW-1:0]         quot;
   logic [DW-1:0]         low;
   logic [FLAG_WIDTH-1:0] flag_in;

   assign is_mul    = (cmd_ff == CMD_MUL);
   assign is_divmod = (cmd_ff == CMD_DIV) || (cmd_ff == CMD_MOD);

   assign status.iterate = (req_cmd == CMD_MUL) || (req_cmd == CMD_DIV) ||
                           (req_cmd == CMD_MOD);

   // operand magnitudes, the minimum maps onto itself as an unsigned value
   assign a_in  = req_operand_a[DW-1:0];
   assign b_in  = req_operand_b[DW-1:0];
   assign ma_in = a_in[DW-1] ? (~a_in + 1'b1) : a_in;
   assign mb_in = b_in[DW-1] ? (~b_in + 1'b1) : b_in;

   // shared adder: add for shift-add multiply, subtract for restoring divide
   always_comb begin
      if (is_mul) begin
         add_x = {1'b0, p_ff[DW2-1:DW]};
         add_y = {1'b0, ma_ff};
      end else begin
         add_x = {p_ff[DW2-1:DW], p_ff[DW-1]};
         add_y = ~{1'b0, mb_ff};
      end
      add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(DW+1){1'b0}}, !is_mul};
      div_ok  = add_sum[DW+1];
      div_hi  = div_ok ? add_sum[DW-1:0] : add_x[DW-1:0];
      if (is_mul) begin
         // multiplier bit set: add the multiplicand, otherwise just shift
         if (p_ff[0]) begin
            p_in = {add_sum[DW:0], p_ff[DW-1:1]};
         end else begin
            p_in = {1'b0, p_ff[DW2-1:1]};
         end
      end else begin
         p_in = {div_hi, p_ff[DW-2:0], div_ok};
      end
   end

   // wide result from the stored operands or the iteration register
   always_comb begin
      wide_in = '0;
      upd_in  = 1'b1;
      err_in  = 1'b0;
      quot    = neg_ff ? (~p_ff[DW-1:0] + 1'b1) : p_ff[DW-1:0];
      case (cmd_ff)
         CMD_ADD: begin
            wide_in = DW2'(signed'(a_ff)) + DW2'(signed'(b_ff));
         end
         CMD_SUB: begin
            wide_in = DW2'(signed'(a_ff)) + DW2'(signed'(DW'(~b_ff + 1'b1)));
         end
         CMD_MUL: begin
            wide_in = neg_ff ? (~p_ff + 1'b1) : p_ff;
         end
         CMD_DIV, CMD_MOD: begin
            if ((b_ff == '0) || (b_ff == MIN_VAL)) begin
               err_in = 1'b1;
               upd_in = 1'b0;
            end else if (a_ff == MIN_VAL) begin
               wide_in = '0;
            end else if (cmd_ff == CMD_DIV) begin
               wide_in = DW2'(signed'(quot));
            end else begin
               wide_in = DW2'(signed'(p_ff[DW2-1:DW]));
            end
         end
         default: begin
            upd_in = 1'b0;
         end
      endcase
   end

   // flags of the wide value
   always_comb begin
      low     = wide_ff[DW-1:0];
      flag_in = flag_ff;
      if (upd_ff) begin
         flag_in = flag_ff & ~FLAG_MASK;
         flag_in[FLAG_ZERO]   = (low == '0);
         flag_in[FLAG_SIGN]   = low[DW-1];
         flag_in[FLAG_PARITY] = ^low[7:0];
         flag_in[FLAG_CARRY]  = |wide_ff[DW2-1:DW];
         flag_in[FLAG_OVF]    = |wide_ff[DW2-1:DW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (cmd.write) begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         a_ff   <= a_in;
         b_ff   <= b_in;
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         neg_ff <= a_in[DW-1] ^ b_in[DW-1];
         if (req_cmd == CMD_MUL) begin
            p_ff <= {{DW{1'b0}}, mb_in};
         end else begin
            p_ff <= {{DW{1'b0}}, ma_in};
         end
      end else if (cmd.step && (is_mul || is_divmod)) begin
         p_ff <= p_in;
      end
      if (cmd.form) begin
         wide_ff <= wide_in;
         upd_ff  <= upd_in;
         err_ff  <= err_in;
      end
      if (cmd.write) begin
         rsp_result_value <= upd_ff ? VALUE_WIDTH'(signed'(low)) : '0;
         rsp_status_flags <= flag_in;
         rsp_divide_error <= err_ff;
      end
   end

endmodule

`default_nettype wire

// File: src/integer_alu_with_status_flags_top.sv
// top level of the integer alu with status flags
// instantiates ialu_ctrl and ialu_dp, depends on ialu_pkg
//
// usage
// - request channel (req_valid/req_ready) carries one transaction: an operation
//   code (add, subtract, multiply, divide, modulo) and two signed operands,
//   of which the low DATA_WIDTH bits are used, sign-extended
// - response channel (rsp_valid/rsp_ready) returns one transaction per request:
//   the low DATA_WIDTH bits of the result sign-extended to 32 bits, the status
//   byte (carry, parity, zero, sign, overflow) and the divide error bit
// - add, subtract and undefined codes: after acceptance the result is formed, then
//   written to the response register; multiply, divide, modulo first run the
//   shift-add / restoring-divide loop, one operand bit per cycle on one adder
// - a new request can be taken in the same cycle that the response appears
// - one transaction in flight; req_ready is high whenever no operation is
//   being worked on, so a new request is taken while the last response waits
// - if the receiver stalls, the finished result holds in the datapath until
//   the response register frees up
// - divide by zero or by the minimum value gives result 0, error 1, flags kept
// - synchronous reset clears the flag register and the handshake state
`default_nettype none

module integer_alu_with_status_flags_top #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire [ialu_pkg::CMD_WIDTH-1:0]            req_cmd,
   input  wire signed [ialu_pkg::VALUE_WIDTH-1:0]   req_operand_a,
   input  wire signed [ialu_pkg::VALUE_WIDTH-1:0]   req_operand_b,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic signed [ialu_pkg::VALUE_WIDTH-1:0]  rsp_result_value,
   output logic [ialu_pkg::FLAG_WIDTH-1:0]          rsp_status_flags,
   output logic                                     rsp_divide_error
);
   import ialu_pkg::*;

   // command and status between the state machine and the datapath
   ialu_cmd_type    ctrl_cmd;
   ialu_status_type dp_status;

   // sequencing: idle, iterate, form wide result, write response register
   ialu_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // operands, iteration register, flag register and response payload
   ialu_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_cmd          (req_cmd),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_result_value (rsp_result_value),
      .rsp_status_flags (rsp_status_flags),
      .rsp_divide_error (rsp_divide_error)
   );

`ifndef ASSERT_OFF
   // only one transaction in the datapath at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an operation was in progress");

   // an error response carries a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_result_value == '0)
      else $error("divide error with nonzero result");

   // a set zero flag implies a zero result whenever no error is reported
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_error && rsp_status_flags[FLAG_ZERO]
      |-> rsp_result_value == '0)
      else $error("zero flag set with nonzero result");

   // carry and overflow always agree
   a_carry_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_flags[FLAG_CARRY] == rsp_status_flags[FLAG_OVF])
      else $error("carry and overflow flags differ");
`endif

endmodule

`default_nettype wire
